// ----- rtl/mcr_pkg.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Widths, register indexes, reset values and the step record passed from the
// front end to the result generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

  localparam int COORD_BITS  = 11;
  localparam int RADIUS_BITS = COORD_BITS - 1;
  localparam int OUT_BITS    = COORD_BITS + 2;
  // Walker x and y are signed: y can drop to minus one on a zero radius.
  localparam int STEP_BITS   = COORD_BITS + 1;
  localparam int DEC_BITS    = COORD_BITS + 3;
  localparam int CANVAS_BITS = 12;
  localparam int CMP_BITS    = (OUT_BITS > CANVAS_BITS + 1) ? OUT_BITS + 1 : CANVAS_BITS + 2;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CANVAS_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CANVAS_HEIGHT = 1'd1;

  localparam logic [CANVAS_BITS-1:0] CANVAS_WIDTH_RESET  = 12'd800;
  localparam logic [CANVAS_BITS-1:0] CANVAS_HEIGHT_RESET = 12'd600;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

  localparam int SEL_BITS = 3;

  typedef struct packed {
    logic [COORD_BITS-1:0]       cx;
    logic [COORD_BITS-1:0]       cy;
    logic signed [STEP_BITS-1:0] x;
    logic signed [STEP_BITS-1:0] y;
    logic                        fill;
    logic                        done;
  } mcr_job_t;

  typedef struct packed {
    logic [CANVAS_BITS-1:0] width;
    logic [CANVAS_BITS-1:0] height;
  } mcr_canvas_t;

endpackage

`default_nettype wire

// ----- rtl/mcr_if.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer channels
// Command channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcr_cmd_if import mcr_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius;
  logic                   fill;

  modport source (output valid, op, center_x, center_y, radius, fill, input ready);
  modport sink   (input valid, op, center_x, center_y, radius, fill, output ready);
endinterface

interface mcr_pix_if import mcr_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] span_left;
  logic signed [OUT_BITS-1:0] span_right;
  logic signed [OUT_BITS-1:0] row;
  logic                       on_canvas;
  logic                       last_of_step;
  logic                       circle_done;

  modport source (output valid, span_left, span_right, row, on_canvas, last_of_step,
                  circle_done, input ready);
  modport sink   (input valid, span_left, span_right, row, on_canvas, last_of_step,
                  circle_done, output ready);
endinterface

`default_nettype wire

// ----- rtl/mcr_front.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer front end
// Takes commands, holds the octant walker and queues one record per step.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_front import mcr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  mcr_cmd_if.sink   cmd,
  input  wire logic q_full,
  output logic      push,
  output mcr_job_t  push_job
);

  logic                        active;
  logic [COORD_BITS-1:0]       cx;
  logic [COORD_BITS-1:0]       cy;
  logic signed [STEP_BITS-1:0] x;
  logic signed [STEP_BITS-1:0] y;
  logic signed [DEC_BITS-1:0]  d;
  logic                        fill_mode;

  logic                        accept;
  logic signed [STEP_BITS-1:0] x_next;
  logic signed [STEP_BITS-1:0] y_next;
  logic signed [DEC_BITS-1:0]  d_next;
  logic signed [DEC_BITS-1:0]  grow;
  logic                        done_next;

  assign cmd.ready = !q_full;
  assign accept    = cmd.valid && cmd.ready;
  assign push      = accept && (cmd.op == OP_ADVANCE) && active;

  always_comb begin
    x_next = x + STEP_BITS'(1);
    if (d < 0) begin
      y_next = y;
      grow   = DEC_BITS'(x_next);
    end else begin
      y_next = y - STEP_BITS'(1);
      grow   = DEC_BITS'(x_next) - DEC_BITS'(y_next);
    end
    d_next    = d + (grow <<< 1) + DEC_BITS'(1);
    done_next = x_next > y_next;
  end

  // The record carries the walker position before the step is taken.
  always_comb begin
    push_job.cx   = cx;
    push_job.cy   = cy;
    push_job.x    = x;
    push_job.y    = y;
    push_job.fill = fill_mode;
    push_job.done = done_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      cx        <= '0;
      cy        <= '0;
      x         <= '0;
      y         <= '0;
      d         <= '0;
      fill_mode <= 1'b0;
    end else if (accept) begin
      if (cmd.op == OP_START) begin
        active    <= 1'b1;
        cx        <= cmd.center_x;
        cy        <= cmd.center_y;
        x         <= '0;
        y         <= STEP_BITS'(cmd.radius);
        d         <= DEC_BITS'(1) - DEC_BITS'(cmd.radius);
        fill_mode <= cmd.fill;
      end else if (active) begin
        x      <= x_next;
        y      <= y_next;
        d      <= d_next;
        active <= !done_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mcr_queue.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer step queue
// Short FIFO of step records between the front end and the result generator.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_queue import mcr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire mcr_job_t push_job,
  input  wire logic     pop,
  output logic          full,
  output logic          not_empty,
  output mcr_job_t      head
);

  mcr_job_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]     wr_ptr;
  logic [PTR_BITS-1:0]     rd_ptr;
  logic [COUNT_BITS-1:0]   count;
  logic                    do_push;
  logic                    do_pop;

  assign full      = count == COUNT_BITS'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - COUNT_BITS'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mcr_back.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer result generator
// Expands one step record into points or spans, clips or flags each against
// the canvas; presents one per cycle from an output register unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_back import mcr_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire mcr_canvas_t canvas,
  input  wire logic        job_valid,
  input  wire mcr_job_t    job,
  output logic             pop,
  mcr_pix_if.source        pix
);

  logic [SEL_BITS-1:0]         sel;
  logic                        last;
  logic                        load;
  logic                        swap;
  logic                        vneg;
  logic signed [STEP_BITS-1:0] h_off;
  logic signed [STEP_BITS-1:0] v_off;
  logic signed [CMP_BITS-1:0]  cx_e;
  logic signed [CMP_BITS-1:0]  cy_e;
  logic signed [CMP_BITS-1:0]  plus;
  logic signed [CMP_BITS-1:0]  minus;
  logic signed [CMP_BITS-1:0]  left;
  logic signed [CMP_BITS-1:0]  right;
  logic signed [CMP_BITS-1:0]  row_v;
  logic signed [CMP_BITS-1:0]  w_e;
  logic signed [CMP_BITS-1:0]  h_e;
  logic signed [CMP_BITS-1:0]  left_c;
  logic signed [CMP_BITS-1:0]  right_c;
  logic                        row_in;
  logic                        on;

  assign last = job.fill ? (sel == SEL_BITS'(3)) : (sel == SEL_BITS'(7));
  assign load = job_valid && (!pix.valid || pix.ready);
  assign pop  = load && last;

  // Outline: bit 2 swaps x and y, bit 1 negates the row offset, bit 0 the
  // column offset. Fill: bit 1 swaps, bit 0 negates the row offset.
  always_comb begin
    swap  = job.fill ? sel[1] : sel[2];
    vneg  = job.fill ? sel[0] : sel[1];
    h_off = swap ? job.y : job.x;
    v_off = swap ? job.x : job.y;
    cx_e  = signed'(CMP_BITS'(job.cx));
    cy_e  = signed'(CMP_BITS'(job.cy));
    plus  = cx_e + CMP_BITS'(h_off);
    minus = cx_e - CMP_BITS'(h_off);
    row_v = vneg ? cy_e - CMP_BITS'(v_off) : cy_e + CMP_BITS'(v_off);
    if (job.fill) begin
      left  = minus;
      right = plus;
    end else begin
      left  = sel[0] ? minus : plus;
      right = left;
    end
  end

  always_comb begin
    w_e     = signed'(CMP_BITS'(canvas.width));
    h_e     = signed'(CMP_BITS'(canvas.height));
    row_in  = (row_v >= 0) && (row_v < h_e);
    left_c  = (left < 0) ? '0 : left;
    right_c = (right > w_e - CMP_BITS'(1)) ? w_e - CMP_BITS'(1) : right;
    if (job.fill) begin
      on = row_in && (left_c <= right_c);
    end else begin
      on = row_in && (left >= 0) && (left < w_e);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
      sel       <= '0;
    end else if (load) begin
      pix.valid <= 1'b1;
      sel       <= last ? '0 : sel + SEL_BITS'(1);
    end else if (pix.ready) begin
      pix.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix.span_left    <= job.fill ? OUT_BITS'(left_c) : OUT_BITS'(left);
      pix.span_right   <= job.fill ? OUT_BITS'(right_c) : OUT_BITS'(right);
      pix.row          <= OUT_BITS'(row_v);
      pix.on_canvas    <= on;
      pix.last_of_step <= last;
      pix.circle_done  <= last && job.done;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/midpoint_circle_rasterizer_top.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer
// Octant walker front end, step queue and clipped result generator.
// ----------------------------------------------------------------------------
// A start command loads centre, radius and mode and gives no result; each
// advance command is one octant step and gives eight points in outline mode
// or four horizontal spans in fill mode. The result generator delivers one
// result per cycle while the result channel is ready; the front end takes a
// command every cycle while the two-entry step queue has room. Canvas size
// may only be changed while the block is idle.
`default_nettype none

module midpoint_circle_rasterizer_top import mcr_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CANVAS_BITS-1:0]    cfg_data,
  mcr_cmd_if.sink                        cmd,
  mcr_pix_if.source                      pix
);

  mcr_canvas_t canvas;
  logic        push;
  mcr_job_t    push_job;
  logic        q_full;
  logic        q_not_empty;
  mcr_job_t    q_head;
  logic        pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas.width  <= CANVAS_WIDTH_RESET;
      canvas.height <= CANVAS_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CANVAS_WIDTH:  canvas.width  <= cfg_data;
        CFG_CANVAS_HEIGHT: canvas.height <= cfg_data;
      endcase
    end
  end

  mcr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  mcr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mcr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .canvas    (canvas),
    .job_valid (q_not_empty),
    .job       (q_head),
    .pop       (pop),
    .pix       (pix)
  );

endmodule

`default_nettype wire

// ----- rtl/mcr_checker.sv -----
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_checker import mcr_pkg::*; (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       pix_valid,
  input wire logic                       pix_ready,
  input wire logic signed [OUT_BITS-1:0] pix_left,
  input wire logic signed [OUT_BITS-1:0] pix_right,
  input wire logic signed [OUT_BITS-1:0] pix_row,
  input wire logic                       pix_on,
  input wire logic                       pix_last,
  input wire logic                       pix_done
);

  // A stalled result must hold still until it is transferred.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pix_left) && $stable(pix_right)
      && $stable(pix_row) && $stable(pix_on) && $stable(pix_last) && $stable(pix_done))
    else $error("result changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_done |-> pix_last)
    else $error("circle end flagged on a result that does not close its step");

  a_on_nonneg: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_on |-> (pix_row >= 0) && (pix_left >= 0) && (pix_right >= 0)
      && (pix_left <= pix_right))
    else $error("on-canvas result with coordinates outside the canvas");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !pix_valid)
    else $error("result presented straight after reset");

endmodule

bind midpoint_circle_rasterizer_top mcr_checker u_mcr_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_valid (pix.valid),
  .pix_ready (pix.ready),
  .pix_left  (pix.span_left),
  .pix_right (pix.span_right),
  .pix_row   (pix.row),
  .pix_on    (pix.on_canvas),
  .pix_last  (pix.last_of_step),
  .pix_done  (pix.circle_done)
);

`default_nettype wire
